// ===== design/sssp_pkg.sv =====
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants
// Field structs and sizing constants for the shortest path unit.
// ----------------------------------------------------------------------------
package sssp_pkg;

   localparam int MAX_NODES   = 32;
   localparam int NODE_BITS   = $clog2(MAX_NODES);
   localparam int CNT_BITS    = NODE_BITS + 1;
   localparam int WEIGHT_BITS = 16;
   localparam int DIST_BITS   = 21;
   localparam int ADDR_BITS   = 2 * NODE_BITS;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_RUN   = 1'b1;

   localparam logic [0:0] REG_NODE_COUNT  = 1'b0;
   localparam logic [0:0] REG_SOURCE_NODE = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [4:0]             from_node;
      logic [4:0]             to_node;
      logic [WEIGHT_BITS-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [4:0]           node;
      logic [DIST_BITS-1:0] distance;
      logic                 reachable;
      logic                 last;
   } rsp_type;

endpackage

// ===== design/single_source_shortest_path_unit.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_path_unit: Dijkstra over an adjacency matrix
// Edge writes store weights; a run computes distances from the source.
// ----------------------------------------------------------------------------
// Edge write: a write is taken every cycle when idle.
// Run: each round scans N distances (select) then N matrix entries
// (relax), and the distances are then sent out as results.
// After reset a clearing pass writes zero to all 1024 matrix entries,
// one per cycle, before any item is accepted.
module single_source_shortest_path_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sssp_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sssp_pkg::rsp_type      rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int NB = sssp_pkg::NODE_BITS;
   localparam int CB = sssp_pkg::CNT_BITS;
   localparam int DB = sssp_pkg::DIST_BITS;
   localparam int AB = sssp_pkg::ADDR_BITS;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SEL, S_REL_RD, S_REL, S_OUT
   } state_type;

   state_type state_ff;

   logic [5:0]       node_count_ff;
   logic [NB-1:0]    source_node_ff;
   logic [CB-1:0]    cnt_ff;
   logic [AB-1:0]    clr_ff;
   logic [CB-1:0]    idx_ff;
   logic [NB-1:0]    pick_ff;
   logic             found_ff;
   logic [DB-1:0]    pick_dist_ff;
   logic [sssp_pkg::MAX_NODES-1:0] visited_ff;
   logic [sssp_pkg::MAX_NODES-1:0] reached_ff;
   logic [DB-1:0]    dist_mem [0:sssp_pkg::MAX_NODES-1];
   logic [DB-1:0]    dist_rd;
   logic [NB-1:0]    dist_rd_idx_ff;
   logic             dist_rd_ok_ff;
   logic             dist_rd_ok_in;
   logic             rsp_valid_ff;
   sssp_pkg::rsp_type rsp_data_ff;

   logic             csr_wr;
   logic [CB-1:0]    cnt_in;
   logic             adj_wr;
   logic [AB-1:0]    adj_waddr;
   logic [sssp_pkg::WEIGHT_BITS-1:0] adj_wdata;
   logic [AB-1:0]    adj_raddr;
   logic [sssp_pkg::WEIGHT_BITS-1:0] adj_rd;
   logic             req_take;
   logic             dist_we;
   logic [NB-1:0]    dist_widx;
   logic [DB-1:0]    dist_wdata;
   logic [NB-1:0]    dist_ridx;
   logic [NB-1:0]    idx_n;
   logic [DB:0]      sum;
   logic [DB-1:0]    sum_sat;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == sssp_pkg::REG_SOURCE_NODE)
                     ? {{(32-NB){1'b0}}, source_node_ff}
                     : {26'd0, node_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= 6'd32;
         source_node_ff <= '0;
      end else if (csr_wr && csr_paddr[1:0] == 2'b00) begin
         case (csr_paddr[2])
            sssp_pkg::REG_NODE_COUNT:  node_count_ff  <= csr_pwdata[5:0];
            sssp_pkg::REG_SOURCE_NODE: source_node_ff <= csr_pwdata[NB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (node_count_ff == 6'd0) cnt_in = CB'(1);
      else if (node_count_ff > 6'(sssp_pkg::MAX_NODES)) cnt_in = CB'(sssp_pkg::MAX_NODES);
      else cnt_in = CB'(node_count_ff);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign idx_n     = idx_ff[NB-1:0];

   // Matrix port: clearing sweep, edge writes.
   always_comb begin
      adj_wr    = 1'b0;
      adj_waddr = {req_data.from_node[NB-1:0], req_data.to_node[NB-1:0]};
      adj_wdata = req_data.weight;
      if (state_ff == S_CLEAR) begin
         adj_wr    = 1'b1;
         adj_waddr = clr_ff;
         adj_wdata = '0;
      end else if (req_take && req_data.mode == sssp_pkg::MODE_WRITE) begin
         adj_wr = 1'b1;
      end
   end

   // Relax reads row pick, column idx.
   assign adj_raddr = {pick_ff, idx_n};

   sssp_adj_mem u_adj (
      .clock   (clock),
      .wr_en   (adj_wr),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_addr (adj_raddr),
      .rd_data (adj_rd)
   );

   // Distance memory: read address is the scan index; read data is registered.
   assign dist_ridx = idx_n;
   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_widx] <= dist_wdata;
      dist_rd <= dist_mem[dist_ridx];
   end

   assign sum     = {1'b0, pick_dist_ff} + (DB+1)'(adj_rd);
   assign sum_sat = sum[DB] ? sssp_pkg::DIST_MAX : sum[DB-1:0];

   always_comb begin
      dist_we    = 1'b0;
      dist_widx  = dist_rd_idx_ff;
      dist_wdata = sum_sat;
      if (state_ff == S_IDLE) begin
         dist_we    = req_take && req_data.mode == sssp_pkg::MODE_RUN;
         dist_widx  = source_node_ff;
         dist_wdata = '0;
      end else if (state_ff == S_REL && dist_rd_ok_ff) begin
         // Write only if the edge exists and improves an unvisited node.
         dist_we = (adj_rd != '0) && !visited_ff[dist_rd_idx_ff] &&
                   (!reached_ff[dist_rd_idx_ff] || sum_sat < dist_rd);
      end
   end

   // A distance read issued this cycle is valid to use in the next one.
   always_comb begin
      case (state_ff)
         S_SEL:    dist_rd_ok_in = (idx_ff < cnt_ff);
         S_REL_RD: dist_rd_ok_in = 1'b1;
         S_REL:    dist_rd_ok_in = (idx_ff < cnt_ff);
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               dist_rd_ok_in = (idx_ff != cnt_ff) && (idx_n != source_node_ff) &&
                               !dist_rd_ok_ff;
            end else begin
               dist_rd_ok_in = dist_rd_ok_ff;
            end
         end
         default:  dist_rd_ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         dist_rd_ok_ff <= 1'b0;
         visited_ff    <= '0;
         reached_ff    <= '0;
         found_ff      <= 1'b0;
         idx_ff        <= '0;
      end else begin
         dist_rd_idx_ff <= idx_n;
         dist_rd_ok_ff  <= dist_rd_ok_in;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_take && req_data.mode == sssp_pkg::MODE_RUN &&
                   CB'(source_node_ff) < cnt_in) begin
                  cnt_ff     <= cnt_in;
                  visited_ff <= '0;
                  reached_ff <= {{(sssp_pkg::MAX_NODES-1){1'b0}}, 1'b1} << source_node_ff;
                  idx_ff     <= '0;
                  found_ff   <= 1'b0;
                  state_ff   <= S_SEL;
               end
            end
            S_SEL: begin
               // Issue reads idx 0..cnt-1, compare the returned entry.
               if (idx_ff < cnt_ff) begin
                  idx_ff <= idx_ff + 1'b1;
               end
               if (dist_rd_ok_ff && reached_ff[dist_rd_idx_ff] &&
                   !visited_ff[dist_rd_idx_ff] &&
                   (!found_ff || dist_rd < pick_dist_ff)) begin
                  found_ff     <= 1'b1;
                  pick_ff      <= dist_rd_idx_ff;
                  pick_dist_ff <= dist_rd;
               end
               if (idx_ff == cnt_ff && !dist_rd_ok_ff) begin
                  idx_ff <= '0;
                  if (found_ff) begin
                     visited_ff[pick_ff] <= 1'b1;
                     state_ff <= S_REL_RD;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_REL_RD: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_REL;
            end
            S_REL: begin
               // One column per cycle; matrix and distance reads line up.
               if (dist_we) reached_ff[dist_rd_idx_ff] <= 1'b1;
               if (idx_ff < cnt_ff) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= S_SEL;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  if (idx_ff == cnt_ff) begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= S_IDLE;
                  end else if (idx_n == source_node_ff) begin
                     rsp_valid_ff <= 1'b0;
                     idx_ff       <= idx_ff + 1'b1;
                  end else if (!dist_rd_ok_ff) begin
                     // Fetch the entry first.
                     rsp_valid_ff <= 1'b0;
                  end else begin
                     rsp_valid_ff          <= 1'b1;
                     rsp_data_ff.node      <= 5'(idx_n);
                     rsp_data_ff.reachable <= reached_ff[idx_n];
                     rsp_data_ff.distance  <= reached_ff[idx_n] ? dist_rd : '0;
                     rsp_data_ff.last      <= (idx_ff + 1'b1 == cnt_ff) ||
                        ((idx_ff + 2'd2 == cnt_ff) &&
                         (CB'(source_node_ff) == idx_ff + 1'b1));
                     idx_ff                <= idx_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("input taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data)) else $error("result changed");
   a_src_reached: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEL) |-> reached_ff[source_node_ff]) else $error("source lost");
   a_out_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && state_ff != S_OUT) |-> $past(rsp_data.last) || rsp_stall ||
      $past(rsp_valid)) else $error("stray result");

endmodule

// ===== design/sssp_adj_mem.sv =====
// ----------------------------------------------------------------------------
// sssp_adj_mem: adjacency matrix storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sssp_adj_mem (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [sssp_pkg::ADDR_BITS-1:0]      wr_addr,
   input  logic [sssp_pkg::WEIGHT_BITS-1:0]    wr_data,
   input  logic [sssp_pkg::ADDR_BITS-1:0]      rd_addr,
   output logic [sssp_pkg::WEIGHT_BITS-1:0]    rd_data
);

   logic [sssp_pkg::WEIGHT_BITS-1:0] mem [0:(1 << sssp_pkg::ADDR_BITS)-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
